@@ design/pct_pkg.sv @@
// Shared types for the per-id completion tracker.
// Used by pct_lookup and per_id_completion_tracker; no dependencies.
package pct_pkg;

  // Command codes carried on the cmd field of an item.
  typedef enum logic [1:0] {
    CMD_ADD_ISSUED = 2'd0,
    CMD_ADD_DONE   = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_REMOVE     = 2'd3
  } cmd_e;

  // Outcome of a key search over the table.
  typedef struct packed {
    logic hit;   // key is present in a valid slot
    logic room;  // at least one slot is free
  } lookup_t;

  // Slot update request applied when an item finishes.
  typedef struct packed {
    logic alloc;  // claim the slot for a new key
    logic clear;  // release the slot
  } tbl_upd_t;

endpackage

@@ design/pct_cnt_ram.sv @@
// Single-port-write, single-port-read synchronous RAM for the count pairs.
// Read data is registered. No dependencies.
module pct_cnt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pct_lookup.sv @@
// Key store with per-slot valid bits and parallel match for the tracker.
// Depends on pct_pkg for the lookup result and update types.
module pct_lookup #(
  parameter int ENTRIES = 16,
  parameter int KEY_BITS = 16,
  parameter int IDX_BITS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [KEY_BITS-1:0]   key_i,
  output pct_pkg::lookup_t      res_o,
  output logic [IDX_BITS-1:0]   hit_idx_o,
  output logic [IDX_BITS-1:0]   free_idx_o,
  input  pct_pkg::tbl_upd_t     upd_i,
  input  logic [IDX_BITS-1:0]   upd_idx_i,
  input  logic [KEY_BITS-1:0]   upd_key_i
);

  logic [KEY_BITS-1:0] key_q [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;
  logic [ENTRIES-1:0]  match;

  // Each slot compares its own key against the search key.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == key_i);
    end
  end

  // Lowest matching slot and lowest free slot.
  always_comb begin
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_o = IDX_BITS'(i);
      end
      if (!valid_q[i]) begin
        free_idx_o = IDX_BITS'(i);
      end
    end
    res_o.hit  = |match;
    res_o.room = ~&valid_q;
  end

  // Valid bits clear on reset; keys are only read behind a valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (upd_i.alloc) begin
      valid_q[upd_idx_i] <= 1'b1;
    end else if (upd_i.clear) begin
      valid_q[upd_idx_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.alloc) begin
      key_q[upd_idx_i] <= upd_key_i;
    end
  end

endmodule

@@ design/per_id_completion_tracker.sv @@
// An item is accepted while the count RAM reads its slot; its result is then
// computed, written back and registered at the output, which a stall can delay.
// No new item is taken until the current one has finished its read-modify-write.
// Reset clears the valid bits, the occupancy count and the handshake state;
// the count RAM and key store are not cleared and need no clearing pass.
// Depends on pct_pkg, pct_lookup and pct_cnt_ram.
module per_id_completion_tracker #(
  parameter int ENTRIES = 16,
  parameter int KEY_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] conn_key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic        complete_o,
  output logic [15:0] issued_now_o,
  output logic [15:0] completed_now_o,
  output logic [4:0]  occupancy_o,
  output logic        overflow_o
);

  localparam int IdxBits = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OccBits = $clog2(ENTRIES + 1);

  // Handshake and stage registers.
  logic                  accept;
  logic                  finish;
  logic                  busy_q;
  logic                  out_valid_q;
  pct_pkg::cmd_e         cmd_q;
  pct_pkg::lookup_t      look_q;
  logic [IdxBits-1:0]    slot_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [OccBits-1:0]    occ_q;
  logic [OccBits-1:0]    occ_d;

  // Search side.
  logic [KEY_BITS+15:0]  key_wide;
  logic [KEY_BITS-1:0]   key;
  pct_pkg::lookup_t      look;
  logic [IdxBits-1:0]    hit_idx;
  logic [IdxBits-1:0]    free_idx;

  // Count RAM side.
  logic [2*COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0]   iss_rd;
  logic [COUNT_BITS-1:0]   cmp_rd;
  logic [COUNT_BITS-1:0]   iss_new;
  logic [COUNT_BITS-1:0]   cmp_new;
  logic                    wr_cnt;
  logic                    present;
  logic                    ovf;
  pct_pkg::tbl_upd_t       upd;
  pct_pkg::tbl_upd_t       upd_gated;

  // Result formatting.
  logic [COUNT_BITS-1:0]   iss_out;
  logic [COUNT_BITS-1:0]   cmp_out;
  logic [COUNT_BITS+15:0]  iss_wide;
  logic [COUNT_BITS+15:0]  cmp_wide;
  logic [OccBits+4:0]      occ_wide;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  assign accept     = in_valid_i && !busy_q;
  assign finish     = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q;

  // Only the low KEY_BITS of the key take part in the search.
  assign key_wide = {{KEY_BITS{1'b0}}, conn_key_i};
  assign key      = key_wide[KEY_BITS-1:0];

  pct_lookup #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .IDX_BITS (IdxBits)
  ) u_lookup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key),
    .res_o      (look),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .upd_i      (upd_gated),
    .upd_idx_i  (slot_q),
    .upd_key_i  (key_q)
  );

  pct_cnt_ram #(
    .DEPTH     (ENTRIES),
    .WIDTH     (2 * COUNT_BITS),
    .ADDR_BITS (IdxBits)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (wr_cnt && finish),
    .waddr_i (slot_q),
    .wdata_i ({iss_new, cmp_new}),
    .re_i    (accept),
    .raddr_i (look.hit ? hit_idx : free_idx),
    .rdata_o (rdata)
  );

  assign iss_rd = rdata[2*COUNT_BITS-1:COUNT_BITS];
  assign cmp_rd = rdata[COUNT_BITS-1:0];

  // Capture the command and the search outcome while the RAM reads the slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (finish) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= pct_pkg::cmd_e'(cmd_i);
      look_q <= look;
      slot_q <= look.hit ? hit_idx : free_idx;
      key_q  <= key;
    end
  end

  // Modify step: new counts, table update and result flags.
  always_comb begin
    iss_new = iss_rd;
    cmp_new = cmp_rd;
    wr_cnt  = 1'b0;
    present = 1'b0;
    ovf     = 1'b0;
    upd     = '0;
    unique case (cmd_q)
      pct_pkg::CMD_ADD_ISSUED: begin
        if (look_q.hit) begin
          iss_new = sat_inc(iss_rd);
          wr_cnt  = 1'b1;
          present = 1'b1;
        end else if (look_q.room) begin
          iss_new   = sat_inc('0);
          cmp_new   = '0;
          wr_cnt    = 1'b1;
          present   = 1'b1;
          upd.alloc = 1'b1;
        end else begin
          ovf = 1'b1;
        end
      end
      pct_pkg::CMD_ADD_DONE: begin
        if (look_q.hit) begin
          cmp_new = sat_inc(cmp_rd);
          wr_cnt  = 1'b1;
          present = 1'b1;
        end
      end
      pct_pkg::CMD_QUERY: begin
        present = look_q.hit;
      end
      pct_pkg::CMD_REMOVE: begin
        upd.clear = look_q.hit;
      end
      default: begin
        present = 1'b0;
      end
    endcase
  end

  assign upd_gated.alloc = upd.alloc && finish;
  assign upd_gated.clear = upd.clear && finish;

  // Occupancy after the command.
  always_comb begin
    occ_d = occ_q;
    if (upd.alloc) begin
      occ_d = occ_q + OccBits'(1);
    end else if (upd.clear) begin
      occ_d = occ_q - OccBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (finish) begin
      occ_q <= occ_d;
    end
  end

  assign iss_out  = present ? iss_new : '0;
  assign cmp_out  = present ? cmp_new : '0;
  assign iss_wide = {16'b0, iss_out};
  assign cmp_wide = {16'b0, cmp_out};
  assign occ_wide = {5'b0, occ_d};

  // Output register: holds a result until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      hit_o           <= look_q.hit;
      complete_o      <= present && (iss_new == cmp_new);
      issued_now_o    <= iss_wide[15:0];
      completed_now_o <= cmp_wide[15:0];
      occupancy_o     <= occ_wide[4:0];
      overflow_o      <= ovf;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/pct_checker.sv @@
// Port-level checks for per_id_completion_tracker, attached with bind.
// Depends only on the top level's ports.
module pct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  cmd_i,
  input logic [15:0] conn_key_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hit_o,
  input logic        complete_o,
  input logic [15:0] issued_now_o,
  input logic [15:0] completed_now_o,
  input logic [4:0]  occupancy_o,
  input logic        overflow_o
);

  // A stalled result stays valid and keeps its counts and occupancy.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(issued_now_o)
      && $stable(completed_now_o) && $stable(occupancy_o))
    else $error("stalled result changed");

  // One item at a time: the cycle after an item is taken, input is stalled.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous one in flight");

  // A dropped add never hits and reports an absent entry.
  a_overflow_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> !hit_o && !complete_o
      && issued_now_o == 16'd0 && completed_now_o == 16'd0)
    else $error("overflow with hit or nonzero counts");

  // Completion means the two reported counts agree.
  a_complete_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && complete_o |-> issued_now_o == completed_now_o)
    else $error("complete with unequal counts");

  // No result is shown and input is not stalled during reset.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("handshake active during reset");

endmodule

bind per_id_completion_tracker pct_checker u_pct_checker (.*);
